// ===== hdl/mvpp_pkg.sv =====
`default_nettype none
package mvpp_pkg;

  localparam int NUM_VIEWS_DEF = 4;
  localparam int FRAC_BITS_DEF = 16;

  // Quotient bits resolved per divider stage.
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = 32 / DIV_STEPS;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE      = 3'd0,
    REG_CLIP_LEVEL = 3'd1,
    REG_ASPECT     = 3'd2,
    REG_ROT_COS    = 3'd3,
    REG_ROT_SIN    = 3'd4
  } cfg_reg_t;

  localparam logic signed [31:0] SCALE_RST  = 32'sd65536;
  localparam logic signed [31:0] CLIP_RST   = 32'sd65536;
  localparam logic [30:0]        ASPECT_RST = 31'd117965;
  localparam logic signed [17:0] COS_RST    = 18'sd0;
  localparam logic signed [17:0] SIN_RST    = 18'sd65536;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Fields that ride along with a result through the divider.
  typedef struct packed {
    logic              vis;
    logic [1:0]        idx;
    logic              last;
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic              neg_x;
    logic              neg_y;
    logic              ovf_x;
    logic              ovf_y;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007fffffff) begin
      r = S32_MAX;
    end else if (v < -64'sh0000000080000000) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == S32_MIN) begin
      r = S32_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/multi_view_perspective_projector.sv =====
`default_nettype none
// Multi-view perspective projector.
// A point (point_x, point_y, point_z, signed Q16.16) is taken at a clock edge
// where start is high and busy is low. The block then emits NUM_VIEWS results,
// one per cycle in view order, each marked by a one-cycle result_valid pulse
// with screen_x, screen_y, visible, view_index and last_view.
// The (x, y) pair is rotated by the configured angle before view 0 and between views.
// After each acceptance busy stays high while a pacing counter runs down, so
// new points are spaced to match the one-result-per-cycle output channel.
// Points overlap inside the pipeline.
// A point passes through the rotation chain, two stages per view, a view
// serializer, an emit register, a product stage, a magnitude stage and 16
// divider stages, each resolving two quotient bits, then the output register.
// Registers are written through cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data; writes to unknown indexes are ignored.
// Synchronous reset restores register defaults and empties the pipeline.
// The receiver cannot stall: each result is present for exactly one cycle.
module multi_view_perspective_projector #(
  parameter int NUM_VIEWS = mvpp_pkg::NUM_VIEWS_DEF,
  parameter int FRAC_BITS = mvpp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [31:0]             point_x,
  input  wire logic signed [31:0]             point_y,
  input  wire logic signed [31:0]             point_z,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mvpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output logic                                result_valid,
  output logic signed [31:0]                  screen_x,
  output logic signed [31:0]                  screen_y,
  output logic                                visible,
  output logic [1:0]                          view_index,
  output logic                                last_view
);

  localparam int VW = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;
  localparam int NDS = mvpp_pkg::DIV_STAGES;
  localparam logic [VW-1:0] LAST_CNT = VW'(NUM_VIEWS - 1);

  // Configuration registers.
  logic signed [31:0] scale;
  logic signed [31:0] clip_level;
  logic [30:0]        aspect_ratio;
  logic signed [17:0] rot_cosine;
  logic signed [17:0] rot_sine;
  logic signed [63:0] clip_prod;
  logic signed [31:0] clip_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= mvpp_pkg::SCALE_RST;
      clip_level   <= mvpp_pkg::CLIP_RST;
      aspect_ratio <= mvpp_pkg::ASPECT_RST;
      rot_cosine   <= mvpp_pkg::COS_RST;
      rot_sine     <= mvpp_pkg::SIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mvpp_pkg::REG_SCALE:      scale        <= cfg_data;
        mvpp_pkg::REG_CLIP_LEVEL: clip_level   <= cfg_data;
        mvpp_pkg::REG_ASPECT:     aspect_ratio <= cfg_data[30:0];
        mvpp_pkg::REG_ROT_COS:    rot_cosine   <= cfg_data[17:0];
        mvpp_pkg::REG_ROT_SIN:    rot_sine     <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // Horizontal clip magnitude: clip_level times aspect_ratio is registered as a product, then saturated into clip_h.
  always_ff @(posedge clk) begin
    clip_prod <= clip_level * $signed({1'b0, aspect_ratio});
    clip_h    <= mvpp_pkg::sat32(clip_prod >>> FRAC_BITS);
  end

  // Input acceptance and pacing.
  logic          accept;
  logic [VW-1:0] gap_cnt;

  assign accept = start && !busy;
  assign busy   = (gap_cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_cnt <= '0;
    end else if (accept) begin
      gap_cnt <= LAST_CNT;
    end else if (gap_cnt != '0) begin
      gap_cnt <= gap_cnt - 1'b1;
    end
  end

  // Rotation chain: two stages per view, carrying the finished views along.
  logic               mv  [NUM_VIEWS];
  logic signed [31:0] mz  [NUM_VIEWS];
  logic signed [49:0] m_cx [NUM_VIEWS];
  logic signed [49:0] m_sy [NUM_VIEWS];
  logic signed [49:0] m_sx [NUM_VIEWS];
  logic signed [49:0] m_cy [NUM_VIEWS];
  logic signed [31:0] mvx [NUM_VIEWS][NUM_VIEWS];
  logic signed [31:0] mvy [NUM_VIEWS][NUM_VIEWS];
  logic               sv  [NUM_VIEWS];
  logic signed [31:0] sz  [NUM_VIEWS];
  logic signed [31:0] svx [NUM_VIEWS][NUM_VIEWS];
  logic signed [31:0] svy [NUM_VIEWS][NUM_VIEWS];

  for (genvar k = 0; k < NUM_VIEWS; k++) begin : g_rot
    logic               in_v;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [50:0] nx;
    logic signed [50:0] ny;

    if (k == 0) begin : g_first
      assign in_v = accept;
      assign in_x = point_x;
      assign in_y = point_y;
      assign in_z = point_z;
      always_ff @(posedge clk) begin
        mvx[k] <= '{default: '0};
        mvy[k] <= '{default: '0};
      end
    end else begin : g_next
      assign in_v = sv[k-1];
      assign in_x = svx[k-1][k-1];
      assign in_y = svy[k-1][k-1];
      assign in_z = sz[k-1];
      always_ff @(posedge clk) begin
        mvx[k] <= svx[k-1];
        mvy[k] <= svy[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mv[k] <= 1'b0;
        sv[k] <= 1'b0;
      end else begin
        mv[k] <= in_v;
        sv[k] <= mv[k];
      end
    end

    always_ff @(posedge clk) begin
      mz[k]   <= in_z;
      m_cx[k] <= rot_cosine * in_x;
      m_sy[k] <= rot_sine * in_y;
      m_sx[k] <= rot_sine * in_x;
      m_cy[k] <= rot_cosine * in_y;
    end

    assign nx = 51'(m_cx[k]) - 51'(m_sy[k]);
    assign ny = 51'(m_sx[k]) + 51'(m_cy[k]);

    always_ff @(posedge clk) begin
      sz[k] <= mz[k];
      for (int j = 0; j < NUM_VIEWS; j++) begin
        if (j == k) begin
          svx[k][j] <= mvpp_pkg::sat32(64'(nx >>> FRAC_BITS));
          svy[k][j] <= mvpp_pkg::sat32(64'(ny >>> FRAC_BITS));
        end else begin
          svx[k][j] <= mvx[k][j];
          svy[k][j] <= mvy[k][j];
        end
      end
    end
  end

  // Serializer: one view per cycle out of a shift buffer.
  logic signed [31:0] buf_x [NUM_VIEWS];
  logic signed [31:0] buf_y [NUM_VIEWS];
  logic signed [31:0] buf_z;
  logic               ser_act;
  logic [VW-1:0]      ser_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_act <= 1'b0;
      ser_cnt <= '0;
    end else if (sv[NUM_VIEWS-1]) begin
      ser_act <= 1'b1;
      ser_cnt <= '0;
    end else if (ser_act) begin
      ser_cnt <= ser_cnt + 1'b1;
      if (ser_cnt == LAST_CNT) begin
        ser_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sv[NUM_VIEWS-1]) begin
      buf_x <= svx[NUM_VIEWS-1];
      buf_y <= svy[NUM_VIEWS-1];
      buf_z <= sz[NUM_VIEWS-1];
    end else if (ser_act) begin
      for (int j = 0; j < NUM_VIEWS - 1; j++) begin
        buf_x[j] <= buf_x[j+1];
        buf_y[j] <= buf_y[j+1];
      end
    end
  end

  // Emit register for the current view.
  logic               e_valid;
  logic signed [31:0] e_x;
  logic signed [31:0] e_y;
  logic signed [31:0] e_z;
  logic [1:0]         e_idx;
  logic               e_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= ser_act;
    end
  end

  always_ff @(posedge clk) begin
    e_x    <= buf_x[0];
    e_y    <= buf_y[0];
    e_z    <= buf_z;
    e_idx  <= 2'(ser_cnt);
    e_last <= (ser_cnt == LAST_CNT);
  end

  // Product stage.
  logic               p_valid;
  logic signed [63:0] p_nx;
  logic signed [63:0] p_nz;
  logic signed [31:0] p_den;
  logic               p_vis;
  logic [1:0]         p_idx;
  logic               p_last;
  logic signed [31:0] p_cx;
  logic signed [31:0] p_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_nx   <= scale * e_x;
    p_nz   <= scale * e_z;
    p_den  <= e_y;
    p_vis  <= (e_y > 32'sd0);
    p_idx  <= e_idx;
    p_last <= e_last;
    p_cx   <= (e_x > 32'sd0) ? clip_h : mvpp_pkg::neg_sat32(clip_h);
    p_cy   <= (e_z > 32'sd0) ? clip_level : mvpp_pkg::neg_sat32(clip_level);
  end

  // Magnitude stage feeds the divider pipeline at index 0.
  logic [63:0] abs_x;
  logic [63:0] abs_z;

  assign abs_x = p_nx[63] ? 64'(-p_nx) : 64'(p_nx);
  assign abs_z = p_nz[63] ? 64'(-p_nz) : 64'(p_nz);

  logic            dv    [NDS+1];
  mvpp_pkg::side_t dside [NDS+1];
  logic [31:0]     dden  [NDS+1];
  logic [31:0]     rem_x [NDS+1];
  logic [31:0]     low_x [NDS+1];
  logic [31:0]     rem_y [NDS+1];
  logic [31:0]     low_y [NDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    dden[0]         <= p_den;
    rem_x[0]        <= abs_x[63:32];
    low_x[0]        <= abs_x[31:0];
    rem_y[0]        <= abs_z[63:32];
    low_y[0]        <= abs_z[31:0];
    dside[0].vis    <= p_vis;
    dside[0].idx    <= p_idx;
    dside[0].last   <= p_last;
    dside[0].clip_x <= p_cx;
    dside[0].clip_y <= p_cy;
    dside[0].neg_x  <= p_nx[63];
    dside[0].neg_y  <= p_nz[63];
    dside[0].ovf_x  <= (abs_x[63:32] >= p_den);
    dside[0].ovf_y  <= (abs_z[63:32] >= p_den);
  end

  // Restoring divider: quotient bits shift into the low word.
  for (genvar s = 0; s < NDS; s++) begin : g_div
    logic [31:0] nrx;
    logic [31:0] nlx;
    logic [31:0] nry;
    logic [31:0] nly;

    always_comb begin
      logic [32:0] tx;
      logic [32:0] ty;
      nrx = rem_x[s];
      nlx = low_x[s];
      nry = rem_y[s];
      nly = low_y[s];
      for (int b = 0; b < mvpp_pkg::DIV_STEPS; b++) begin
        tx = {nrx, nlx[31]};
        ty = {nry, nly[31]};
        if (tx >= {1'b0, dden[s]}) begin
          tx  = tx - {1'b0, dden[s]};
          nlx = {nlx[30:0], 1'b1};
        end else begin
          nlx = {nlx[30:0], 1'b0};
        end
        if (ty >= {1'b0, dden[s]}) begin
          ty  = ty - {1'b0, dden[s]};
          nly = {nly[30:0], 1'b1};
        end else begin
          nly = {nly[30:0], 1'b0};
        end
        nrx = tx[31:0];
        nry = ty[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      dden[s+1]  <= dden[s];
      dside[s+1] <= dside[s];
      rem_x[s+1] <= nrx;
      low_x[s+1] <= nlx;
      rem_y[s+1] <= nry;
      low_y[s+1] <= nly;
    end
  end

  // Sign, saturation and clip selection.
  mvpp_pkg::side_t    fs;
  logic signed [31:0] qx;
  logic signed [31:0] qy;

  assign fs = dside[NDS];

  always_comb begin
    if (fs.neg_x) begin
      qx = (fs.ovf_x || low_x[NDS] > 32'h80000000) ? mvpp_pkg::S32_MIN
                                                     : -$signed(low_x[NDS]);
    end else begin
      qx = (fs.ovf_x || low_x[NDS][31]) ? mvpp_pkg::S32_MAX : $signed(low_x[NDS]);
    end
    if (fs.neg_y) begin
      qy = (fs.ovf_y || low_y[NDS] > 32'h80000000) ? mvpp_pkg::S32_MIN
                                                     : -$signed(low_y[NDS]);
    end else begin
      qy = (fs.ovf_y || low_y[NDS][31]) ? mvpp_pkg::S32_MAX : $signed(low_y[NDS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dv[NDS];
    end
  end

  always_ff @(posedge clk) begin
    screen_x   <= fs.vis ? qx : fs.clip_x;
    screen_y   <= fs.vis ? qy : fs.clip_y;
    visible    <= fs.vis;
    view_index <= fs.idx;
    last_view  <= fs.last;
  end

endmodule
`default_nettype wire
